/* rtl/core/ccs_pkg.sv */
// Shared types and constants for the comment stripper.
// No dependencies; every other file of the block imports this package.
package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_t;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4
    } mode_t;

    // Results of one item: how many (0..2) and their bytes in order.
    typedef struct packed {
        logic [1:0] num;
        logic [7:0] char0;
        logic [7:0] char1;
    } push_t;

endpackage

/* rtl/core/ccs_fsm.sv */
// Scan mode register and per-byte decode of the comment stripper.
// Depends on ccs_pkg.
module ccs_fsm
    import ccs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  in_t   item,
    output push_t push
);

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [7:0] c;
    logic       is_slash;
    logic       is_star;
    logic       is_nl;

    assign c        = item.in_char;
    assign is_slash = (c == CH_SLASH);
    assign is_star  = (c == CH_STAR);
    assign is_nl    = (c == CH_NL);

    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (is_slash)
                    mode_next = MODE_LINE;
                else if (is_star)
                    mode_next = MODE_BLOCK;
                else
                    mode_next = MODE_NORMAL;
            end
            MODE_LINE:
            begin
                if (is_nl)
                    mode_next = MODE_NORMAL;
            end
            MODE_BLOCK, MODE_BLOCK_STAR:
            begin
                if (mode_reg == MODE_BLOCK_STAR && is_slash)
                    mode_next = MODE_NORMAL;
                else if (is_star)
                    mode_next = MODE_BLOCK_STAR;
                else
                    mode_next = MODE_BLOCK;
            end
            default:
            begin
                if (is_slash && !item.in_last)
                    mode_next = MODE_SLASH;
                else
                    mode_next = MODE_NORMAL;
            end
        endcase
        if (item.in_last)
            mode_next = MODE_NORMAL;
    end

    always_comb
    begin
        push.num   = 2'd0;
        push.char0 = c;
        push.char1 = c;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (is_slash)
                begin
                    push.num   = 2'd1;
                    push.char0 = CH_NL;
                end
                else if (!is_star)
                begin
                    push.num   = 2'd2;
                    push.char0 = CH_SLASH;
                end
            end
            MODE_LINE:
            begin
                push.num = 2'd0;
            end
            MODE_BLOCK, MODE_BLOCK_STAR:
            begin
                if (is_nl)
                    push.num = 2'd1;
            end
            default:
            begin
                if (!is_slash || item.in_last)
                    push.num = 2'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NORMAL;
        else if (fire)
            mode_reg <= mode_next;
    end

endmodule

/* rtl/core/ccs_obuf.sv */
// Four-entry result queue; takes up to two results per cycle, gives at most one.
// Depends on ccs_pkg.
module ccs_obuf
    import ccs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    out_t       entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] num;
    logic       pop;

    assign num       = fire ? push.num : 2'd0;
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= 3'd2);
    assign out_data  = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + num;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, num} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (num != 2'd0)
        begin
            entry_reg[wr_ptr_reg].out_char <= push.char0;
            entry_reg[wr_ptr_reg].out_last <= (num == 2'd1);
        end
        if (num == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1].out_char <= push.char1;
            entry_reg[wr_ptr_reg + 2'd1].out_last <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/c_comment_stripper_top.sv */
// Top level of the C comment stripper: input register, mode decode, result queue.
// Depends on ccs_pkg, ccs_fsm, ccs_obuf.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data  (in_t: in_char, in_last)
//   out      output     out_valid / out_ready out_data (out_t: out_char, out_last)
//
// One byte per cycle while the queue has room; a byte that yields two results
// takes two queue entries. A byte taken in waits in the input register until
// the queue has room; its results are then written into the queue.
// The result queue holds four entries; input is taken while
// the input register is empty or is being consumed, which needs two free
// entries. Reset returns the scan mode to normal text and empties the queue.
module c_comment_stripper_top
    import ccs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic  in_valid_reg;
    logic  in_valid_next;
    in_t   in_data_reg;
    logic  room;
    logic  fire;
    push_t push;

    assign fire          = in_valid_reg && room;
    assign in_ready      = !in_valid_reg || fire;
    assign in_valid_next = (in_valid && in_ready) || (in_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
    end

    ccs_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_data_reg),
        .push  (push)
    );

    ccs_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* rtl/core/ccs_checker.sv */
// Port-level checks for the comment stripper, bound to the top level.
// Depends on ccs_pkg and c_comment_stripper_top.
module ccs_checker
    import ccs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // Queue is empty right after reset.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high right after reset");

    // Input only stalls when results are waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // The second result of a pair is ready right behind the first.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.out_last |=> out_valid)
        else $error("second result of a pair missing");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind c_comment_stripper_top ccs_checker u_ccs_checker (.*);
